// File: sv/psrsd_pkg.sv
// shared constants and types for the per-source event rate spike detector
package psrsd_pkg;

    // default sizes
    localparam int DEF_SOURCES    = 64;
    localparam int DEF_RING_DEPTH = 256;

    // register reset values
    localparam logic [15:0] SHORT_WIN_RST  = 16'd60;
    localparam logic [15:0] BASE_WIN_RST   = 16'd3600;
    localparam logic [15:0] THRESH_RST     = 16'd768;
    localparam logic [15:0] MIN_THRESH_Q8  = 16'd282;

    // spike qualification
    localparam int MIN_SHORT_EVENTS = 5;
    localparam int MIN_BASE_EVENTS  = 10;

    // full severity in Q1.8
    localparam logic [8:0] SEV_FULL = 9'd256;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_SHORT_WIN = 2'd0,
        CFG_BASE_WIN  = 2'd1,
        CFG_THRESH    = 2'd2
    } cfg_idx_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_SH_RD,
        ST_SH_CHK,
        ST_BL_RD,
        ST_BL_CHK,
        ST_MUL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// File: sv/per_source_event_rate_spike_detector.sv
// top level of the per-source event rate spike detector
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+-------------------------------------------
//  s_       | in        | s_valid / s_ready      | has_source, source_id, event_time
//  m_       | out       | m_valid / m_ready      | tracked, is_spike, counts, ratio, severity
//  cfg_     | in        | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// an untracked item goes straight to the output; a tracked one walks the entries that leave
// the two windows, its time set by the one-read-a-cycle timestamp memory walk and the
// 16-step ratio divider, which is skipped when the ratio saturates
// after reset the per-source table is cleared before s_ready rises
// a waiting result does not block the next item from being accepted; the next result
// holds in the sequencer until the output register is free
// cfg_ready is always high
module per_source_event_rate_spike_detector
    import psrsd_pkg::*;
#(
    parameter int SOURCES    = DEF_SOURCES,
    parameter int RING_DEPTH = DEF_RING_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_has_source,
    input  logic [5:0]  s_source_id,
    input  logic [31:0] s_event_time,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_tracked,
    output logic        m_is_spike,
    output logic [8:0]  m_short_count,
    output logic [8:0]  m_baseline_count,
    output logic [15:0] m_ratio_q8,
    output logic [8:0]  m_severity_q8,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int SRC_W  = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int RING_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int AW     = $clog2(SOURCES * RING_DEPTH);
    localparam int PW     = CNT_W + 16;

    typedef struct packed {
        logic [RING_W-1:0] newest;
        logic [RING_W-1:0] s_old;
        logic [RING_W-1:0] b_old;
        logic [CNT_W-1:0]  s_tot;
        logic [CNT_W-1:0]  b_tot;
    } meta_t;

    function automatic logic [RING_W-1:0] next_slot(input logic [RING_W-1:0] s);
        next_slot = (s == RING_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    // memories
    logic [31:0] ts_mem [SOURCES*RING_DEPTH];
    meta_t       meta_mem [SOURCES];
    logic [31:0] ts_rd_reg;
    meta_t       meta_rd_reg;
    logic        ts_we;
    logic [AW-1:0] ts_wa, ts_ra;
    logic        meta_we;
    logic [SRC_W-1:0] meta_wa;
    meta_t       meta_wd;
    logic [SRC_W-1:0] in_idx;
    logic [31:0] src_ext;

    // state
    state_t state_reg, state_next;
    logic [SRC_W-1:0] clr_reg, clr_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [31:0] now_reg, now_next;
    logic        trk_reg, trk_next;
    meta_t       w_reg, w_next;
    logic [PW-1:0] lhs_reg, lhs_next, rhs_reg, rhs_next, rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next, sh_reg, sh_next;
    logic [3:0]  bit_reg, bit_next;
    logic        sat_reg, sat_next;
    logic [15:0] sw_reg, bw_reg, th_reg;

    // output register
    logic        mv_reg, mv_next;
    logic        o_trk_reg, o_trk_next, o_spk_reg, o_spk_next;
    logic [8:0]  o_sc_reg, o_sc_next, o_bc_reg, o_bc_next, o_sev_reg, o_sev_next;
    logic [15:0] o_rat_reg, o_rat_next;

    // helpers
    logic [AW-1:0] ts_base;
    logic [15:0] sw_eff, bw_eff, th_eff;
    logic [31:0] age;
    logic        sh_over, bl_over;
    logic [PW:0] rem_sh;
    logic [RING_W-1:0] slot;
    logic        out_free, accept, in_range;
    logic [31:0] sc_ext, bc_ext;
    logic        spike;

    assign src_ext  = 32'(s_source_id);
    assign in_idx   = src_ext[SRC_W-1:0];
    assign in_range = src_ext < 32'(SOURCES);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_free = !mv_reg || m_ready;

    assign ts_base = AW'(src_reg * RING_DEPTH);
    assign ts_ra   = ts_base + AW'((state_reg == ST_BL_RD) ? w_reg.b_old : w_reg.s_old);
    assign age     = now_reg - ts_rd_reg;
    assign sh_over = (now_reg >= ts_rd_reg) && (age > {16'b0, sw_reg});
    assign bl_over = (now_reg >= ts_rd_reg) && (age > {16'b0, bw_reg});
    assign sw_eff  = (sw_reg == '0) ? 16'd1 : sw_reg;
    assign bw_eff  = (bw_reg == '0) ? 16'd1 : bw_reg;
    assign th_eff  = (th_reg < MIN_THRESH_Q8) ? MIN_THRESH_Q8 : th_reg;
    assign rem_sh  = {rem_reg, sh_reg[15]};
    assign slot    = next_slot(meta_rd_reg.newest);
    assign sc_ext  = 32'(w_reg.s_tot);
    assign bc_ext  = 32'(w_reg.b_tot);

    // timestamp memory
    always_ff @(posedge aclk) begin
        if (ts_we) begin
            ts_mem[ts_wa] <= now_reg;
        end
        ts_rd_reg <= ts_mem[ts_ra];
    end

    // per-source table
    always_ff @(posedge aclk) begin
        if (meta_we) begin
            meta_mem[meta_wa] <= meta_wd;
        end
        meta_rd_reg <= meta_mem[in_idx];
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sw_reg <= SHORT_WIN_RST;
            bw_reg <= BASE_WIN_RST;
            th_reg <= THRESH_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SHORT_WIN: sw_reg <= cfg_data;
                CFG_BASE_WIN:  bw_reg <= cfg_data;
                CFG_THRESH:    th_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // sequencer registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            mv_reg    <= mv_next;
        end
        src_reg   <= src_next;
        now_reg   <= now_next;
        trk_reg   <= trk_next;
        w_reg     <= w_next;
        lhs_reg   <= lhs_next;
        rhs_reg   <= rhs_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        sh_reg    <= sh_next;
        bit_reg   <= bit_next;
        sat_reg   <= sat_next;
        o_trk_reg <= o_trk_next;
        o_spk_reg <= o_spk_next;
        o_sc_reg  <= o_sc_next;
        o_bc_reg  <= o_bc_next;
        o_sev_reg <= o_sev_next;
        o_rat_reg <= o_rat_next;
    end

    // spike decision from quotient and remainder
    assign spike = (w_reg.b_tot != '0)
                && (sat_reg || (quo_reg > th_eff) || ((quo_reg == th_eff) && (rem_reg != '0)))
                && (sc_ext >= 32'(MIN_SHORT_EVENTS)) && (bc_ext >= 32'(MIN_BASE_EVENTS));

    // next state and datapath
    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        src_next   = src_reg;
        now_next   = now_reg;
        trk_next   = trk_reg;
        w_next     = w_reg;
        lhs_next   = lhs_reg;
        rhs_next   = rhs_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        sh_next    = sh_reg;
        bit_next   = bit_reg;
        sat_next   = sat_reg;
        mv_next    = mv_reg && !m_ready;
        o_trk_next = o_trk_reg;
        o_spk_next = o_spk_reg;
        o_sc_next  = o_sc_reg;
        o_bc_next  = o_bc_reg;
        o_sev_next = o_sev_reg;
        o_rat_next = o_rat_reg;
        ts_we      = 1'b0;
        ts_wa      = ts_base + AW'(slot);
        meta_we    = 1'b0;
        meta_wa    = src_reg;
        meta_wd    = w_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                meta_we  = 1'b1;
                meta_wa  = clr_reg;
                meta_wd  = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SRC_W'(SOURCES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    src_next = in_idx;
                    now_next = s_event_time;
                    trk_next = s_has_source && in_range;
                    state_next = (s_has_source && in_range) ? ST_META : ST_DONE;
                end
            end
            ST_META: begin
                // drop oldest on a full ring, then append the new entry
                w_next = meta_rd_reg;
                if (meta_rd_reg.s_tot >= CNT_W'(RING_DEPTH)) begin
                    w_next.s_old = next_slot(meta_rd_reg.s_old);
                    w_next.s_tot = meta_rd_reg.s_tot - 1'b1;
                end
                if (meta_rd_reg.b_tot >= CNT_W'(RING_DEPTH)) begin
                    w_next.b_old = next_slot(meta_rd_reg.b_old);
                    w_next.b_tot = meta_rd_reg.b_tot - 1'b1;
                end
                if (w_next.s_tot == '0) begin
                    w_next.s_old = slot;
                end
                if (w_next.b_tot == '0) begin
                    w_next.b_old = slot;
                end
                w_next.s_tot  = w_next.s_tot + 1'b1;
                w_next.b_tot  = w_next.b_tot + 1'b1;
                w_next.newest = slot;
                ts_we = 1'b1;
                state_next = ST_SH_RD;
            end
            ST_SH_RD: begin
                state_next = (w_reg.s_tot == '0) ? ST_BL_RD : ST_SH_CHK;
            end
            ST_SH_CHK: begin
                if (sh_over) begin
                    w_next.s_old = next_slot(w_reg.s_old);
                    w_next.s_tot = w_reg.s_tot - 1'b1;
                    state_next = ST_SH_RD;
                end else begin
                    state_next = ST_BL_RD;
                end
            end
            ST_BL_RD: begin
                state_next = (w_reg.b_tot == '0) ? ST_MUL : ST_BL_CHK;
            end
            ST_BL_CHK: begin
                if (bl_over) begin
                    w_next.b_old = next_slot(w_reg.b_old);
                    w_next.b_tot = w_reg.b_tot - 1'b1;
                    state_next = ST_BL_RD;
                end else begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // scaled rates and table write-back
                lhs_next = PW'(w_reg.s_tot) * PW'(bw_eff);
                rhs_next = PW'(sw_eff) * PW'(w_reg.b_tot);
                meta_we  = 1'b1;
                state_next = ST_PREP;
            end
            ST_PREP: begin
                sat_next = {8'b0, lhs_reg} >= {rhs_reg, 8'b0};
                rem_next = lhs_reg >> 8;
                sh_next  = {lhs_reg[7:0], 8'h00};
                quo_next = '0;
                bit_next = '0;
                if (rhs_reg == '0 || {8'b0, lhs_reg} >= {rhs_reg, 8'b0}) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle
                sh_next = {sh_reg[14:0], 1'b0};
                if (rem_sh >= {1'b0, rhs_reg}) begin
                    rem_next = PW'(rem_sh - {1'b0, rhs_reg});
                    quo_next = {quo_reg[14:0], 1'b1};
                end else begin
                    rem_next = PW'(rem_sh);
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                bit_next = bit_reg + 1'b1;
                if (bit_reg == 4'd15) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    o_trk_next = trk_reg;
                    if (trk_reg) begin
                        o_spk_next = spike;
                        o_sc_next  = sc_ext[8:0];
                        o_bc_next  = bc_ext[8:0];
                        o_sev_next = spike ? SEV_FULL : 9'd0;
                        if (w_reg.b_tot == '0) begin
                            o_rat_next = 16'd256;
                        end else begin
                            o_rat_next = sat_reg ? 16'hFFFF : quo_reg;
                        end
                    end else begin
                        o_spk_next = 1'b0;
                        o_sc_next  = '0;
                        o_bc_next  = '0;
                        o_sev_next = '0;
                        o_rat_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // result ports
    assign m_valid          = mv_reg;
    assign m_tracked        = o_trk_reg;
    assign m_is_spike       = o_spk_reg;
    assign m_short_count    = o_sc_reg;
    assign m_baseline_count = o_bc_reg;
    assign m_ratio_q8       = o_rat_reg;
    assign m_severity_q8    = o_sev_reg;

endmodule

// File: sv/psrsd_checker.sv
// port-level checks for the spike detector, bound to the top level
module psrsd_checker
    import psrsd_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_tracked,
    input logic        m_is_spike,
    input logic [8:0]  m_short_count,
    input logic [8:0]  m_baseline_count,
    input logic [15:0] m_ratio_q8,
    input logic [8:0]  m_severity_q8
);

    // a stalled item stays offered
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // an untracked item carries an all-zero result
    a_untracked: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_tracked |-> !m_is_spike && m_short_count == 9'd0
            && m_baseline_count == 9'd0 && m_ratio_q8 == 16'd0 && m_severity_q8 == 9'd0)
        else $error("untracked item with nonzero result");

    // a spike has full severity and enough events
    a_spike: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_spike |-> m_severity_q8 == SEV_FULL
            && m_short_count >= 9'(MIN_SHORT_EVENTS)
            && m_baseline_count >= 9'(MIN_BASE_EVENTS))
        else $error("spike without its conditions");

    // no spike means zero severity
    a_nospike: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_is_spike |-> m_severity_q8 == 9'd0)
        else $error("severity without spike");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind per_source_event_rate_spike_detector psrsd_checker u_psrsd_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_tracked        (m_tracked),
    .m_is_spike       (m_is_spike),
    .m_short_count    (m_short_count),
    .m_baseline_count (m_baseline_count),
    .m_ratio_q8       (m_ratio_q8),
    .m_severity_q8    (m_severity_q8)
);

// File: test/per_source_event_rate_spike_detector_tb.sv
// self-checking testbench for the per-source event rate spike detector
`timescale 1ns / 100ps

module per_source_event_rate_spike_detector_tb
    import psrsd_pkg::*;
();

    localparam int NSRC  = 64;
    localparam int DEPTH = 256;
    localparam longint CYCLE_LIMIT = 4000000;

    // one result item
    typedef struct packed {
        logic        tracked;
        logic        is_spike;
        logic [8:0]  short_count;
        logic [8:0]  baseline_count;
        logic [15:0] ratio_q8;
        logic [8:0]  severity_q8;
    } rate_result_t;

    // rate model of the block and store of expected results
    class rate_scoreboard;
        logic [31:0]  stamps [NSRC][DEPTH];
        int unsigned  newest [NSRC];
        int unsigned  sh_old [NSRC];
        int unsigned  bl_old [NSRC];
        int unsigned  sh_cnt [NSRC];
        int unsigned  bl_cnt [NSRC];
        logic [15:0]  short_win, base_win, thresh;
        rate_result_t pending[$];
        int           errors;

        function new();
            for (int s = 0; s < NSRC; s++) begin
                newest[s] = 0; sh_old[s] = 0; bl_old[s] = 0;
                sh_cnt[s] = 0; bl_cnt[s] = 0;
                for (int k = 0; k < DEPTH; k++) stamps[s][k] = '0;
            end
            short_win = SHORT_WIN_RST;
            base_win  = BASE_WIN_RST;
            thresh    = THRESH_RST;
            errors    = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] val);
            case (idx)
                CFG_SHORT_WIN: short_win = val;
                CFG_BASE_WIN:  base_win  = val;
                CFG_THRESH:    thresh    = val;
                default: ;
            endcase
        endfunction

        // drop entries whose age is strictly over the window
        function void age_out(int s, logic [31:0] now, longint win,
                              ref int unsigned oldest, ref int unsigned cnt);
            longint age;
            while (cnt > 0) begin
                age = longint'(now) - longint'(stamps[s][oldest]);
                if (age <= win) break;
                oldest = (oldest + 1) % DEPTH;
                cnt--;
            end
        endfunction

        function void note_event(logic has, logic [5:0] src, logic [31:0] now);
            rate_result_t r;
            int s;
            int unsigned slot;
            longint unsigned c, b, sw, bw, th, lhs, rhs, ratio, sev;
            logic spike;
            r = '0;
            s = src;
            if (!has || s >= NSRC) begin
                pending.insert(pending.size(), r);
                return;
            end
            if (sh_cnt[s] >= DEPTH) begin sh_old[s] = (sh_old[s] + 1) % DEPTH; sh_cnt[s]--; end
            if (bl_cnt[s] >= DEPTH) begin bl_old[s] = (bl_old[s] + 1) % DEPTH; bl_cnt[s]--; end
            slot = (newest[s] + 1) % DEPTH;
            stamps[s][slot] = now;
            newest[s] = slot;
            if (sh_cnt[s] == 0) sh_old[s] = slot;
            sh_cnt[s]++;
            if (bl_cnt[s] == 0) bl_old[s] = slot;
            bl_cnt[s]++;
            age_out(s, now, short_win, sh_old[s], sh_cnt[s]);
            age_out(s, now, base_win, bl_old[s], bl_cnt[s]);
            c  = sh_cnt[s];
            b  = bl_cnt[s];
            sw = (short_win == 0) ? 1 : short_win;
            bw = (base_win == 0) ? 1 : base_win;
            th = (thresh < MIN_THRESH_Q8) ? MIN_THRESH_Q8 : thresh;
            if (b == 0) begin
                ratio = 256;
                spike = 1'b0;
            end else begin
                lhs = c * bw;
                rhs = sw * b;
                ratio = (lhs * 256) / rhs;
                if (ratio > 65535) ratio = 65535;
                spike = (lhs * 256 > th * rhs) && c >= MIN_SHORT_EVENTS
                        && b >= MIN_BASE_EVENTS;
            end
            sev = 0;
            if (spike) begin
                sev = ((c * bw - sw * b) * 65536) / (sw * b * (th - 256));
                if (sev > 256) sev = SEV_FULL;
            end
            r.tracked        = 1'b1;
            r.is_spike       = spike;
            r.short_count    = c[8:0];
            r.baseline_count = b[8:0];
            r.ratio_q8       = ratio[15:0];
            r.severity_q8    = sev[8:0];
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(rate_result_t got);
            rate_result_t exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result item %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending[0];
            pending.delete(0);
            if (got.tracked !== exp_r.tracked)
                report("tracked", exp_r.tracked, got.tracked);
            if (got.is_spike !== exp_r.is_spike)
                report("is_spike", exp_r.is_spike, got.is_spike);
            if (got.short_count !== exp_r.short_count)
                report("short_count", exp_r.short_count, got.short_count);
            if (got.baseline_count !== exp_r.baseline_count)
                report("baseline_count", exp_r.baseline_count, got.baseline_count);
            if (got.ratio_q8 !== exp_r.ratio_q8)
                report("ratio_q8", exp_r.ratio_q8, got.ratio_q8);
            if (got.severity_q8 !== exp_r.severity_q8)
                report("severity_q8", exp_r.severity_q8, got.severity_q8);
        endfunction

        function void report(string field, logic [31:0] e, logic [31:0] a);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, e, a);
            errors++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_has_source = 1'b0;
    logic [5:0]  s_source_id = '0;
    logic [31:0] s_event_time = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_tracked, m_is_spike;
    logic [8:0]  m_short_count, m_baseline_count, m_severity_q8;
    logic [15:0] m_ratio_q8;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    rate_scoreboard sb = new();
    logic [31:0] src_clock [NSRC];
    longint cycles = 0;
    bit     calm = 1'b0;
    bit     long_hold = 1'b0;

    always #5 aclk = ~aclk;

    per_source_event_rate_spike_detector i_dut (.*);

    // cycle limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check accepted items
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result({m_tracked, m_is_spike, m_short_count, m_baseline_count,
                             m_ratio_q8, m_severity_q8});
    end

    // result side: random stall bursts and one long hold-off
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (long_hold) begin
                m_ready <= 1'b0;
                repeat (600) @(posedge aclk);
                long_hold = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 17);
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // valid stays high after an accept until the next item or an idle stretch
    task automatic send_event(logic has, logic [5:0] src, logic [31:0] t);
        int n;
        if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 17);
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_has_source <= has;
        s_source_id  <= src;
        s_event_time <= t;
        do @(posedge aclk); while (!s_ready);
        sb.note_event(has, src, t);
    endtask

    // tracked event on a source, time moves forward by a step
    task automatic send_tracked(logic [5:0] src, int unsigned step);
        src_clock[src] = src_clock[src] + step;
        send_event(1'b1, src, src_clock[src]);
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        while (sb.pending.size() != 0 && guard < 200000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (600) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_all(logic [15:0] sw, logic [15:0] bw, logic [15:0] th);
        drain();
        write_reg(CFG_SHORT_WIN, sw);
        write_reg(CFG_BASE_WIN, bw);
        write_reg(CFG_THRESH, th);
    endtask

    // random phase: mostly bursts on a few sources, some noise
    task automatic random_phase(int items);
        int k;
        logic [5:0] src;
        k = 0;
        while (k < items) begin
            if ($urandom_range(0, 9) == 0) begin
                send_event(1'b0, 6'($urandom), $urandom);
            end else begin
                src = 6'($urandom_range(0, 7));
                if ($urandom_range(0, 4) == 0) src = 6'($urandom);
                case ($urandom_range(0, 3))
                    0: send_tracked(src, $urandom_range(0, 3));
                    1: send_tracked(src, $urandom_range(0, 40));
                    2: send_tracked(src, $urandom_range(0, 400));
                    default: send_tracked(src, (src_clock[src] > 32'hF000_0000) ? 0
                                                : $urandom_range(0, 5000));
                endcase
            end
            k++;
        end
    endtask

    initial begin
        for (int s = 0; s < NSRC; s++) src_clock[s] = $urandom_range(0, 1000);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: no source, extremes of fields, bursts that spike
        send_event(1'b0, 6'h3F, 32'hFFFF_FFFF);
        send_event(1'b0, 6'h00, 32'h0);
        send_event(1'b1, 6'h3F, 32'hFFFF_FFFF);
        send_event(1'b1, 6'h3F, 32'hFFFF_FFFF);
        send_event(1'b1, 6'h3F, 32'h0);
        send_event(1'b1, 6'h00, 32'h0);
        src_clock[1] = 32'h5555_5555;
        for (int i = 0; i < 10; i++) send_tracked(6'd1, 300);
        for (int i = 0; i < 8; i++) send_tracked(6'd1, 1);

        // zero windows and minimum threshold
        set_all(16'd0, 16'd0, 16'd0);
        for (int i = 0; i < 4; i++) send_tracked(6'd2, i & 1);
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(150);
        set_all(16'd1, 16'd65535, 16'd282);
        random_phase(150);
        set_all(16'd10, 16'd200, 16'd300);
        random_phase(300);

        // fill one ring past its depth while the receiver holds off
        set_all(16'd20, 16'd2000, 16'd400);
        long_hold = 1'b1;
        for (int i = 0; i < 300; i++) send_tracked(6'd9, $urandom_range(0, 1));
        set_all(SHORT_WIN_RST, BASE_WIN_RST, THRESH_RST);
        random_phase(500);
        set_all(16'd30, 16'd600, 16'd350);
        calm = 1'b1;
        random_phase(300);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
